@@ rtl/mlpfs_pkg.sv @@
// shared types, constants and the sigmoid lookup table for the mlp forward pass block
// no dependencies; imported by the ram-less modules of the block
package mlpfs_pkg;

   localparam int DEF_INPUT_COUNT    = 3;
   localparam int DEF_HIDDEN_NEURONS = 4;
   localparam int DEF_OUTPUT_COUNT   = 5;
   localparam int DEF_HIDDEN_LAYERS  = 1;

   localparam int SAMPLE_COUNT = 3;
   localparam int WEIGHT_W     = 16;
   localparam int ACT_W        = 13;
   localparam int PROD_W       = 32;
   localparam int ACC_W        = 40;
   localparam int OFF_W        = 29;
   localparam int INDEX_W      = 6;
   localparam int NUMBER_W     = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_INFER = 1'b1;

   localparam int SIG_DEPTH = 256;
   localparam int SIG_IW    = $clog2(SIG_DEPTH);
   localparam int SCALE_W   = OFF_W + SIG_IW + 1;

   localparam logic signed [ACC_W-1:0] CLAMP_Q24 = 40'sd134217728;
   localparam logic [OFF_W-1:0]        OFF_MAX   = 29'h1000_0000;

   localparam longint          CLAMP_L = 64'sd134217728;
   localparam longint unsigned ONE_Q31 = 64'd2147483648;

   typedef logic [ACT_W-1:0] sig_table_type [SIG_DEPTH];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NSTART,
      ST_MAC,
      ST_BIAS,
      ST_FLUSH,
      ST_CLAMP,
      ST_LUT,
      ST_WB,
      ST_NEXT,
      ST_RETURN
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_MORE_IN,
      COND_HOLD,
      COND_NOT_DONE
   } cond_type;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic clr;
      logic mul;
      logic bias;
      logic add;
      logic clamp;
      logic lut;
      logic wb;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic k_last;
      logic hold;
      logic done;
   } status_type;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   function automatic int total_weights(int n_in, int n_hid, int n_out, int n_lay);
      int total;
      if (n_lay > 0) begin
         total = n_hid * (n_in + 1) + (n_lay - 1) * n_hid * (n_hid + 1)
               + n_out * (n_hid + 1);
      end else begin
         total = n_out * (n_in + 1);
      end
      return total;
   endfunction

   // shift and subtract quotient, operands below 2^48
   function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 47; b >= 0; b--) begin
         r = (r << 1) | ((n >> b) & 64'd1);
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic logic [ACT_W-1:0] sig_entry(int i);
      longint unsigned base;
      longint          x;
      longint unsigned t;
      longint unsigned g;
      longint unsigned term;
      longint          s;
      longint unsigned v;
      longint unsigned den;
      longint unsigned num;
      base = longint'(2 * i + 1) << 27;
      x    = longint'(base / SIG_DEPTH) - CLAMP_L;
      t    = (x < 0) ? longint'(-x) : longint'(x);
      g    = t << 4;
      term = ONE_Q31;
      s    = longint'(ONE_Q31);
      for (int k = 1; k <= 24; k++) begin
         term = udiv((term * g) >> 31, longint'(k));
         if ((k & 1) == 1) s = s - longint'(term);
         else              s = s + longint'(term);
      end
      if (s < 0) s = 0;
      v = s;
      if (v > ONE_Q31) v = ONE_Q31;
      for (int k = 0; k < 3; k++) v = (v * v) >> 31;
      den = ONE_Q31 + v;
      num = (x >= 0) ? (64'd1 << 43) : (v << 12);
      return ACT_W'(udiv(num + den / 2, den));
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      for (int i = 0; i < SIG_DEPTH; i++) tab[i] = sig_entry(i);
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

@@ rtl/mlpfs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mlpfs_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 41,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mlpfs_sequencer.sv @@
// microcode sequencer: step counter, control store and conditional jumps
// depends on mlpfs_pkg
module mlpfs_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  mlpfs_pkg::status_type status,
   output mlpfs_pkg::ctrl_type   ctrl
);
   import mlpfs_pkg::*;

   step_type       pc_ff;
   step_type       pc_in;
   ucode_word_type word;

   function automatic ucode_word_type rom(step_type s);
      ucode_word_type w;
      w        = '0;
      w.cond   = COND_NEVER;
      w.target = ST_IDLE;
      unique case (s)
         ST_IDLE: begin
            w.ctrl.accept = 1'b1;
            w.cond        = COND_NO_START;
            w.target      = ST_IDLE;
         end
         ST_NSTART: begin
            w.ctrl.rd_en = 1'b1;
            w.ctrl.clr   = 1'b1;
         end
         ST_MAC: begin
            w.ctrl.rd_en = 1'b1;
            w.ctrl.mul   = 1'b1;
            w.ctrl.add   = 1'b1;
            w.cond       = COND_MORE_IN;
            w.target     = ST_MAC;
         end
         ST_BIAS: begin
            w.ctrl.bias = 1'b1;
            w.ctrl.add  = 1'b1;
         end
         ST_FLUSH: begin
            w.ctrl.add = 1'b1;
         end
         ST_CLAMP: begin
            w.ctrl.clamp = 1'b1;
         end
         ST_LUT: begin
            w.ctrl.lut = 1'b1;
         end
         ST_WB: begin
            w.ctrl.wb = 1'b1;
            w.cond    = COND_HOLD;
            w.target  = ST_WB;
         end
         ST_NEXT: begin
            w.cond   = COND_NOT_DONE;
            w.target = ST_NSTART;
         end
         ST_RETURN: begin
            w.cond   = COND_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      word = rom(pc_ff);
      ctrl = word.ctrl;
   end

   always_comb begin
      step_type seq_step;
      seq_step = step_type'(pc_ff + 4'd1);
      unique case (word.cond)
         COND_NEVER:    pc_in = seq_step;
         COND_ALWAYS:   pc_in = word.target;
         COND_NO_START: pc_in = status.start  ? seq_step : word.target;
         COND_MORE_IN:  pc_in = status.k_last ? seq_step : word.target;
         COND_HOLD:     pc_in = status.hold   ? word.target : seq_step;
         COND_NOT_DONE: pc_in = status.done   ? seq_step : word.target;
         default:       pc_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pc_ff <= ST_IDLE;
      else       pc_ff <= pc_in;
   end

`ifndef SYNTHESIS
   a_idle_waits: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == ST_IDLE && !status.start) |=> (pc_ff == ST_IDLE))
      else $error("sequencer left idle without a start");
`endif

endmodule

@@ rtl/mlpfs_datapath.sv @@
// shared multiply-accumulate datapath: counters, accumulator, clamp, sigmoid lookup,
// hidden activation banks and result register; depends on mlpfs_pkg
module mlpfs_datapath #(
   parameter int INPUT_COUNT    = mlpfs_pkg::DEF_INPUT_COUNT,
   parameter int HIDDEN_NEURONS = mlpfs_pkg::DEF_HIDDEN_NEURONS,
   parameter int OUTPUT_COUNT   = mlpfs_pkg::DEF_OUTPUT_COUNT,
   parameter int HIDDEN_LAYERS  = mlpfs_pkg::DEF_HIDDEN_LAYERS,
   parameter int ADDR_W         = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mlpfs_pkg::ctrl_type                     ctrl,
   output mlpfs_pkg::status_type                   status,
   input  logic                                    start,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0]   sample_0,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0]   sample_1,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0]   sample_2,
   output logic                                    ram_rd_en,
   output logic [ADDR_W-1:0]                       ram_rd_addr,
   input  logic [mlpfs_pkg::WEIGHT_W-1:0]          ram_rd_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mlpfs_pkg::ACT_W-1:0]             rsp_activation,
   output logic [mlpfs_pkg::NUMBER_W-1:0]          rsp_neuron_number,
   output logic                                    rsp_last_output
);
   import mlpfs_pkg::*;

   localparam int MAX_IN = (INPUT_COUNT > HIDDEN_NEURONS) ? INPUT_COUNT : HIDDEN_NEURONS;
   localparam int MAX_NN = (OUTPUT_COUNT > HIDDEN_NEURONS) ? OUTPUT_COUNT : HIDDEN_NEURONS;
   localparam int KW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
   localparam int NW = (MAX_NN > 1) ? $clog2(MAX_NN) : 1;
   localparam int LW = (HIDDEN_LAYERS > 0) ? $clog2(HIDDEN_LAYERS + 1) : 1;
   localparam int HW = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;

   logic signed [WEIGHT_W-1:0] sample_ff [SAMPLE_COUNT];
   logic [ACT_W-1:0]           act_ff [2][HIDDEN_NEURONS];

   logic [KW-1:0]             k_ff, k_in;
   logic [NW-1:0]             neuron_ff, neuron_in;
   logic [LW-1:0]             layer_ff, layer_in;
   logic [ADDR_W-1:0]         wptr_ff, wptr_in;
   logic                      done_ff, done_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [OFF_W-1:0]          off_ff, off_in;
   logic [ACT_W-1:0]          sig_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]          rsp_act_ff;
   logic [NUMBER_W-1:0]       rsp_num_ff;
   logic                      rsp_last_ff;

   logic signed [WEIGHT_W-1:0] w_c;
   logic signed [WEIGHT_W-1:0] x_c;
   logic                       out_layer;
   logic                       k_last;
   logic                       neuron_last;
   logic                       hold;
   logic                       advance;
   logic                       emit;
   logic                       store;
   logic [SCALE_W-1:0]         scaled;
   logic [SCALE_W-29:0]        idx_wide;
   logic [SIG_IW-1:0]          lut_idx;

   assign w_c       = $signed(ram_rd_data);
   assign out_layer = (layer_ff == LW'(HIDDEN_LAYERS));
   assign k_last    = (layer_ff == '0) ? (int'(k_ff) == INPUT_COUNT - 1)
                                       : (int'(k_ff) == HIDDEN_NEURONS - 1);
   assign neuron_last = out_layer ? (int'(neuron_ff) == OUTPUT_COUNT - 1)
                                  : (int'(neuron_ff) == HIDDEN_NEURONS - 1);
   assign hold    = out_layer && rsp_valid_ff && rsp_stall;
   assign advance = ctrl.wb && !hold;
   assign emit    = advance && out_layer;
   assign store   = advance && !out_layer;

   assign status.start  = start;
   assign status.k_last = k_last;
   assign status.hold   = hold;
   assign status.done   = done_ff;

   assign ram_rd_en   = ctrl.rd_en;
   assign ram_rd_addr = wptr_ff;

   // layer input for the current product
   always_comb begin
      if (layer_ff == '0) begin
         priority if (int'(k_ff) == 0) x_c = sample_ff[0];
         else if (int'(k_ff) == 1)     x_c = sample_ff[1];
         else if (int'(k_ff) == 2)     x_c = sample_ff[2];
         else                          x_c = '0;
      end else begin
         x_c = $signed({{(WEIGHT_W - ACT_W){1'b0}}, act_ff[~layer_ff[0]][HW'(k_ff)]});
      end
   end

   always_comb begin
      scaled   = SCALE_W'(off_ff) * SCALE_W'(SIG_DEPTH);
      idx_wide = scaled[SCALE_W-1:28];
      if (int'(idx_wide) >= SIG_DEPTH) lut_idx = SIG_IW'(SIG_DEPTH - 1);
      else                             lut_idx = idx_wide[SIG_IW-1:0];
   end

   always_comb begin
      k_in      = k_ff;
      neuron_in = neuron_ff;
      layer_in  = layer_ff;
      wptr_in   = wptr_ff;
      done_in   = done_ff;
      if (start) begin
         neuron_in = '0;
         layer_in  = '0;
         wptr_in   = '0;
         done_in   = 1'b0;
      end
      if (ctrl.clr) k_in = '0;
      else if (ctrl.mul) k_in = k_ff + 1'b1;
      if (ctrl.rd_en) wptr_in = wptr_ff + 1'b1;
      if (advance) begin
         if (neuron_last) begin
            neuron_in = '0;
            if (out_layer) done_in = 1'b1;
            else           layer_in = layer_ff + 1'b1;
         end else begin
            neuron_in = neuron_ff + 1'b1;
         end
      end
   end

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      off_in  = off_ff;
      if (ctrl.mul)  prod_in = w_c * x_c;
      if (ctrl.bias) prod_in = {{(PROD_W - WEIGHT_W - 12){w_c[WEIGHT_W-1]}}, w_c, 12'b0};
      if (ctrl.add)  acc_in  = acc_ff + ACC_W'(prod_ff);
      if (ctrl.clr) begin
         prod_in = '0;
         acc_in  = '0;
      end
      if (ctrl.clamp) begin
         priority if (acc_ff > CLAMP_Q24) off_in = OFF_MAX;
         else if (acc_ff < -CLAMP_Q24)    off_in = '0;
         else                             off_in = OFF_W'(acc_ff + CLAMP_Q24);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit)            rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         neuron_ff    <= '0;
         layer_ff     <= '0;
         wptr_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         neuron_ff    <= neuron_in;
         layer_ff     <= layer_in;
         wptr_ff      <= wptr_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      off_ff  <= off_in;
      if (start) begin
         sample_ff[0] <= sample_0;
         sample_ff[1] <= sample_1;
         sample_ff[2] <= sample_2;
      end
      if (ctrl.lut) sig_ff <= SIG_TABLE[lut_idx];
      if (store) act_ff[layer_ff[0]][HW'(neuron_ff)] <= sig_ff;
      if (emit) begin
         rsp_act_ff  <= sig_ff;
         rsp_num_ff  <= NUMBER_W'(neuron_ff);
         rsp_last_ff <= neuron_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_activation    = rsp_act_ff;
   assign rsp_neuron_number = rsp_num_ff;
   assign rsp_last_output   = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> (!done_ff && layer_ff == '0 && neuron_ff == '0))
      else $error("inference start did not clear counters");
   a_last_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_num_ff == NUMBER_W'(OUTPUT_COUNT - 1)))
      else $error("last result carries wrong neuron number");
`endif

endmodule

@@ rtl/mlp_forward_pass_sigmoid.sv @@
// top level of the fixed-point mlp forward pass with sigmoid activation
// depends on mlpfs_pkg, mlpfs_ram, mlpfs_sequencer, mlpfs_datapath
//
// request channel (req_*): a transfer with req_command 0 stores req_weight_value at
// req_weight_index (indexes past the last weight are dropped).
// a transfer with req_command 1 runs one inference on req_sample_0..2.
// response channel (rsp_*): one transfer per output neuron, in neuron order,
// rsp_last_output high on the final one; write requests produce no response.
// one shared multiply-accumulate unit walks every neuron under microcode; for each
// neuron it reads, forms one product per input, then adds the bias, flushes, clamps,
// looks up the sigmoid, writes back and branches. after the last response the
// sequencer passes its branch and return steps back to idle, where a new request is
// taken. req_stall is high while an inference runs.
// a stalled response holds the sequencer at its writeback step until the result
// register frees; the other side keeps working up to that point.
// reset (synchronous) returns the sequencer to idle and empties the result register;
// the weight memory is not cleared, so all weights must be written before inference.
module mlp_forward_pass_sigmoid #(
   parameter int INPUT_COUNT    = mlpfs_pkg::DEF_INPUT_COUNT,
   parameter int HIDDEN_NEURONS = mlpfs_pkg::DEF_HIDDEN_NEURONS,
   parameter int OUTPUT_COUNT   = mlpfs_pkg::DEF_OUTPUT_COUNT,
   parameter int HIDDEN_LAYERS  = mlpfs_pkg::DEF_HIDDEN_LAYERS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic [mlpfs_pkg::INDEX_W-1:0]         req_weight_index,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0] req_weight_value,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0] req_sample_0,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0] req_sample_1,
   input  logic signed [mlpfs_pkg::WEIGHT_W-1:0] req_sample_2,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mlpfs_pkg::ACT_W-1:0]           rsp_activation,
   output logic [mlpfs_pkg::NUMBER_W-1:0]        rsp_neuron_number,
   output logic                                  rsp_last_output
);
   import mlpfs_pkg::*;

   localparam int TOTAL  = total_weights(INPUT_COUNT, HIDDEN_NEURONS, OUTPUT_COUNT,
                                         HIDDEN_LAYERS);
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

   ctrl_type          ctrl;
   status_type        status;
   logic              req_fire;
   logic              start;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WEIGHT_W-1:0] ram_rd_data;

   assign req_stall = !ctrl.accept;
   assign req_fire  = req_valid && ctrl.accept;
   assign start     = req_fire && (req_command == CMD_INFER);
   assign wr_en     = req_fire && (req_command == CMD_WRITE)
                      && (int'(req_weight_index) < TOTAL);
   assign wr_addr   = ADDR_W'(req_weight_index);

   mlpfs_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (TOTAL)
   ) u_weights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_weight_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mlpfs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   mlpfs_datapath #(
      .INPUT_COUNT    (INPUT_COUNT),
      .HIDDEN_NEURONS (HIDDEN_NEURONS),
      .OUTPUT_COUNT   (OUTPUT_COUNT),
      .HIDDEN_LAYERS  (HIDDEN_LAYERS),
      .ADDR_W         (ADDR_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .start             (start),
      .sample_0          (req_sample_0),
      .sample_1          (req_sample_1),
      .sample_2          (req_sample_2),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_activation    (rsp_activation),
      .rsp_neuron_number (rsp_neuron_number),
      .rsp_last_output   (rsp_last_output)
   );

endmodule
